FILE: hdl/battery_sampler_fuel_gauge_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the battery sampler fuel gauge
// Clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BATTERY_SAMPLER_FUEL_GAUGE_UNIT_MACROS_SVH
`define BATTERY_SAMPLER_FUEL_GAUGE_UNIT_MACROS_SVH

// same-cycle implication
`define BSFG_ASSERT_NOW(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BSFG_ASSERT_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/bsfg_pkg.sv
// ----------------------------------------------------------------------------
// bsfg_pkg
// Shared types, constants and the LiPo discharge table of the fuel gauge.
// ----------------------------------------------------------------------------
package bsfg_pkg;

	localparam int TABLE_POINTS = 22;
	localparam int IDX_W        = 5;
	localparam int MV_W         = 13;
	localparam int PCT_W        = 7;
	localparam int ADC_W        = 12;
	localparam int SUM_W        = 16;
	localparam int CNT_W        = 4;
	localparam int ELAPSED_W    = 16;
	localparam int SETTLE_W     = 8;
	localparam int NUM_W        = 22;
	localparam int DEN_W        = 14;
	localparam int QUO_W        = 7;
	localparam int STEP_W       = 3;
	localparam int QDEPTH       = 2;
	localparam int QPTR_W       = 1;
	localparam int ADDR_W       = 4;
	localparam int DATA_W       = 32;

	localparam logic [1:0] MODE_TICK  = 2'd0;
	localparam logic [1:0] MODE_BOOT  = 2'd1;
	localparam logic [1:0] MODE_ABORT = 2'd2;

	localparam logic [1:0] REG_INTERVAL = 2'd0;
	localparam logic [1:0] REG_SETTLE   = 2'd1;
	localparam logic [1:0] REG_LOW      = 2'd2;
	localparam logic [1:0] REG_CRIT     = 2'd3;

	localparam logic [ELAPSED_W-1:0] INTERVAL_RST = 16'd6000;
	localparam logic [SETTLE_W-1:0]  SETTLE_RST   = 8'd5;
	localparam logic [PCT_W-1:0]     LOW_RST      = 7'd20;
	localparam logic [PCT_W-1:0]     CRIT_RST     = 7'd10;
	localparam logic [PCT_W-1:0]     PCT_RST      = 7'd100;

	typedef enum logic [1:0] {
		CMD_PASS,
		CMD_AVG,
		CMD_PRIME
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic               divider;
		logic               taken;
		logic [SUM_W-1:0]   value;
	} cmd_t;

	typedef struct packed {
		logic [ELAPSED_W-1:0] interval;
		logic [SETTLE_W-1:0]  settle;
		logic [PCT_W-1:0]     low_level;
		logic [PCT_W-1:0]     critical_level;
	} cfg_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DIV_MUL,
		BK_DIV_FIX,
		BK_FIND,
		BK_PREP,
		BK_DIVIDE,
		BK_SUM,
		BK_DONE
	} back_state_t;

	function automatic logic [MV_W-1:0] lut_mv(input logic [IDX_W-1:0] idx);
		logic [MV_W-1:0] v;
		case (idx)
			5'd0:  v = 13'd4200;
			5'd1:  v = 13'd4150;
			5'd2:  v = 13'd4110;
			5'd3:  v = 13'd4080;
			5'd4:  v = 13'd4020;
			5'd5:  v = 13'd3980;
			5'd6:  v = 13'd3950;
			5'd7:  v = 13'd3910;
			5'd8:  v = 13'd3870;
			5'd9:  v = 13'd3850;
			5'd10: v = 13'd3840;
			5'd11: v = 13'd3820;
			5'd12: v = 13'd3800;
			5'd13: v = 13'd3790;
			5'd14: v = 13'd3770;
			5'd15: v = 13'd3750;
			5'd16: v = 13'd3730;
			5'd17: v = 13'd3710;
			5'd18: v = 13'd3690;
			5'd19: v = 13'd3610;
			5'd20: v = 13'd3500;
			5'd21: v = 13'd3300;
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic [PCT_W-1:0] lut_pct(input logic [IDX_W-1:0] idx);
		logic [PCT_W-1:0] p;
		case (idx)
			5'd0:  p = 7'd100;
			5'd1:  p = 7'd95;
			5'd2:  p = 7'd90;
			5'd3:  p = 7'd85;
			5'd4:  p = 7'd80;
			5'd5:  p = 7'd75;
			5'd6:  p = 7'd70;
			5'd7:  p = 7'd65;
			5'd8:  p = 7'd60;
			5'd9:  p = 7'd55;
			5'd10: p = 7'd50;
			5'd11: p = 7'd45;
			5'd12: p = 7'd40;
			5'd13: p = 7'd35;
			5'd14: p = 7'd30;
			5'd15: p = 7'd25;
			5'd16: p = 7'd20;
			5'd17: p = 7'd15;
			5'd18: p = 7'd10;
			5'd19: p = 7'd5;
			5'd20: p = 7'd2;
			5'd21: p = 7'd0;
			default: p = '0;
		endcase
		return p;
	endfunction

endpackage

FILE: hdl/bsfg_fifo.sv
// ----------------------------------------------------------------------------
// bsfg_fifo
// Two-entry command queue between the front and back of the fuel gauge.
// ----------------------------------------------------------------------------
module bsfg_fifo import bsfg_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  cmd_t  push_data,
	output logic  full,
	input  logic  pop,
	output cmd_t  pop_data,
	output logic  empty
);

	cmd_t                mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QPTR_W:0]     count_q;

	assign full     = (count_q == (QPTR_W+1)'(QDEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: hdl/bsfg_front.sv
// ----------------------------------------------------------------------------
// bsfg_front
// Tick timing, divider control and sample accumulation; emits one command
// per accepted beat.
// ----------------------------------------------------------------------------
module bsfg_front import bsfg_pkg::*; #(
	parameter int SAMPLES_PER_AVERAGE = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       mode,
	input  logic [ADC_W-1:0] adc_mv,
	input  logic             divider_request,
	input  cfg_t             cfg,
	input  logic             q_full,
	output logic             q_push,
	output cmd_t             q_data
);

	localparam logic [CNT_W:0] CNT_LAST = (CNT_W+1)'(SAMPLES_PER_AVERAGE);

	logic                 settling_q, settling_d;
	logic [ELAPSED_W-1:0] elapsed_q, elapsed_d, elapsed_inc;
	logic [CNT_W-1:0]     count_q, count_d;
	logic [SUM_W-1:0]     sum_q, sum_d, sum_add;
	logic                 divider_q, divider_d;

	assign in_ready = !q_full;
	assign q_push   = in_valid && in_ready;

	always_comb begin
		settling_d     = settling_q;
		elapsed_d      = elapsed_q;
		count_d        = count_q;
		sum_d          = sum_q;
		divider_d      = divider_q;
		q_data.kind    = CMD_PASS;
		q_data.taken   = 1'b0;
		q_data.value   = '0;
		// saturating millisecond count
		elapsed_inc    = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;
		sum_add        = sum_q + SUM_W'(adc_mv);
		unique case (mode)
			MODE_TICK: begin
				elapsed_d = elapsed_inc;
				if (!settling_q) begin
					if (elapsed_inc >= cfg.interval) begin
						divider_d  = 1'b1;
						settling_d = 1'b1;
						elapsed_d  = '0;
					end
				end else if (elapsed_inc >= ELAPSED_W'(cfg.settle)) begin
					divider_d    = 1'b0;
					settling_d   = 1'b0;
					elapsed_d    = '0;
					q_data.taken = 1'b1;
					if (({1'b0, count_q} + 1'b1) >= CNT_LAST) begin
						q_data.kind  = CMD_AVG;
						q_data.value = sum_add;
						sum_d        = '0;
						count_d      = '0;
					end else begin
						sum_d   = sum_add;
						count_d = count_q + 1'b1;
					end
				end
			end
			MODE_BOOT: begin
				q_data.kind  = CMD_PRIME;
				q_data.taken = 1'b1;
				q_data.value = SUM_W'(adc_mv);
				sum_d        = '0;
				count_d      = '0;
				divider_d    = 1'b0;
				settling_d   = 1'b0;
				elapsed_d    = '0;
			end
			MODE_ABORT: begin
				divider_d  = divider_request;
				// aborted settle re-enables on the next tick
				if (settling_q) begin
					elapsed_d = cfg.interval;
				end
				settling_d = 1'b0;
			end
			default: begin
			end
		endcase
		q_data.divider = divider_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settling_q <= 1'b0;
			elapsed_q  <= '0;
			count_q    <= '0;
			sum_q      <= '0;
			divider_q  <= 1'b0;
		end else if (q_push) begin
			settling_q <= settling_d;
			elapsed_q  <= elapsed_d;
			count_q    <= count_d;
			sum_q      <= sum_d;
			divider_q  <= divider_d;
		end
	end

endmodule

FILE: hdl/bsfg_back.sv
// ----------------------------------------------------------------------------
// bsfg_back
// Averaging, table interpolation with a bit-serial divider, and the output
// register.
// ----------------------------------------------------------------------------
module bsfg_back import bsfg_pkg::*; #(
	parameter int SAMPLES_PER_AVERAGE = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             q_empty,
	output logic             q_pop,
	input  cmd_t             q_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             divider_on,
	output logic             sample_taken,
	output logic             updated,
	output logic [MV_W-1:0]  battery_mv,
	output logic [PCT_W-1:0] percent,
	output logic             low_flag,
	output logic             critical_flag
);

	// average = (sum * (2^SH / N)) >> SH, then one correction step
	localparam int                 RECIP_SH = 20;
	localparam int                 RECIP_W  = RECIP_SH + 1;
	localparam int                 PROD_W   = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'((1 << RECIP_SH) / SAMPLES_PER_AVERAGE);
	localparam logic [SUM_W-1:0]   NDIV     = SUM_W'(SAMPLES_PER_AVERAGE);
	localparam logic [IDX_W-1:0]   IDX_LAST = IDX_W'(TABLE_POINTS - 1);

	back_state_t          state_q, state_d;
	cmd_t                 cmd_q;
	logic [PROD_W-1:0]    prod_q;
	logic [MV_W-1:0]      voltage_q;
	logic [PCT_W-1:0]     percent_q;
	logic [IDX_W-1:0]     seg_q;
	logic [NUM_W-1:0]     rem_q;
	logic [DEN_W-1:0]     den_q;
	logic [PCT_W-1:0]     plo_q;
	logic [QUO_W-1:0]     quo_q;
	logic [STEP_W-1:0]    step_q;
	logic                 out_valid_q;

	logic                 out_free;
	logic                 out_load;
	cmd_t                 src;
	logic [SUM_W-1:0]     q0, q0n, rem_avg, avg;
	logic                 at_top, at_bottom;
	logic [IDX_W-1:0]     seg;
	logic [IDX_W-1:0]     seg_next;
	logic [MV_W-1:0]      seg_hi, seg_lo, dv, diff;
	logic [PCT_W-1:0]     dp;
	logic [MV_W+PCT_W-1:0] dd;
	logic [NUM_W-1:0]     shifted;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_empty && out_free) begin
					if (q_data.kind == CMD_AVG) begin
						state_d = BK_DIV_MUL;
					end else if (q_data.kind == CMD_PRIME) begin
						state_d = BK_FIND;
					end
				end
			end
			BK_DIV_MUL: state_d = BK_DIV_FIX;
			BK_DIV_FIX: state_d = BK_FIND;
			BK_FIND: begin
				state_d = (at_top || at_bottom) ? BK_DONE : BK_PREP;
			end
			BK_PREP:   state_d = BK_DIVIDE;
			BK_DIVIDE: begin
				if (step_q == '0) begin
					state_d = BK_SUM;
				end
			end
			BK_SUM:    state_d = BK_DONE;
			BK_DONE: begin
				if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			default:   state_d = BK_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		q_pop    = 1'b0;
		out_load = 1'b0;
		src      = cmd_q;
		unique case (state_q)
			BK_IDLE: begin
				src   = q_data;
				q_pop = !q_empty && out_free;
				out_load = q_pop && (q_data.kind == CMD_PASS);
			end
			BK_DONE: out_load = out_free;
			default: begin
			end
		endcase
	end

	// averaging correction
	assign q0      = prod_q[RECIP_SH +: SUM_W];
	assign q0n     = q0 * NDIV;
	assign rem_avg = cmd_q.value - q0n;
	assign avg     = (rem_avg >= NDIV) ? q0 + 1'b1 : q0;

	// segment search: largest point at or above the voltage
	always_comb begin
		at_top    = voltage_q >= lut_mv('0);
		at_bottom = voltage_q <= lut_mv(IDX_LAST);
		seg       = '0;
		for (int j = 0; j < TABLE_POINTS - 1; j++) begin
			if (voltage_q <= lut_mv(IDX_W'(j))) begin
				seg = IDX_W'(j);
			end
		end
	end

	assign seg_next = seg_q + 1'b1;
	assign seg_hi   = lut_mv(seg_q);
	assign seg_lo   = lut_mv(seg_next);
	assign dv       = seg_hi - seg_lo;
	assign diff     = voltage_q - seg_lo;
	assign dp       = lut_pct(seg_q) - lut_pct(seg_next);
	assign dd       = diff * dp;
	assign shifted  = NUM_W'(den_q) << step_q;

	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: begin
				if (q_pop) begin
					cmd_q <= q_data;
				end
			end
			BK_DIV_MUL: prod_q <= PROD_W'(cmd_q.value) * PROD_W'(RECIP);
			BK_FIND:    seg_q  <= seg;
			BK_PREP: begin
				rem_q  <= NUM_W'({dd, 1'b0}) + NUM_W'(dv);
				den_q  <= {dv, 1'b0};
				plo_q  <= lut_pct(seg_next);
				quo_q  <= '0;
				step_q <= STEP_W'(QUO_W - 1);
			end
			BK_DIVIDE: begin
				if (rem_q >= shifted) begin
					rem_q         <= rem_q - shifted;
					quo_q[step_q] <= 1'b1;
				end
				step_q <= step_q - 1'b1;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			divider_on    <= src.divider;
			sample_taken  <= src.taken;
			updated       <= (src.kind != CMD_PASS);
			battery_mv    <= voltage_q;
			percent       <= percent_q;
			low_flag      <= (percent_q <= cfg.low_level);
			critical_flag <= (percent_q <= cfg.critical_level);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			voltage_q   <= '0;
			percent_q   <= PCT_RST;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (q_pop && (q_data.kind == CMD_PRIME)) begin
				voltage_q <= {q_data.value[MV_W-2:0], 1'b0};
			end
			if (state_q == BK_DIV_FIX) begin
				voltage_q <= {avg[MV_W-2:0], 1'b0};
			end
			if (state_q == BK_FIND) begin
				if (at_top) begin
					percent_q <= lut_pct('0);
				end else if (at_bottom) begin
					percent_q <= lut_pct(IDX_LAST);
				end
			end
			if (state_q == BK_SUM) begin
				percent_q <= plo_q + quo_q;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: hdl/battery_sampler_fuel_gauge_unit.sv
// A beat with no new average goes via the queue to the output register; an average
// runs multiply, fix, search, prep, serial divide and sum, a boot reading starts at the
// search, and either skips prep, divide and sum when it clamps at a table end. One beat
// per cycle while no average or boot reading is in flight and out_ready is high; the
// back end holds the next beat meanwhile. Reset (arst_n low) idles the timer,
// clears the sum and divider, sets internal voltage 0 and percent 100, loads defaults.
// ----------------------------------------------------------------------------
// battery_sampler_fuel_gauge_unit
// Battery sampler with averaging and LiPo percent lookup, APB register port.
// ----------------------------------------------------------------------------
module battery_sampler_fuel_gauge_unit import bsfg_pkg::*; #(
	parameter int SAMPLES_PER_AVERAGE = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        mode,
	input  logic [ADC_W-1:0]  adc_mv,
	input  logic              divider_request,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              divider_on,
	output logic              sample_taken,
	output logic              updated,
	output logic [MV_W-1:0]   battery_mv,
	output logic [PCT_W-1:0]  percent,
	output logic              low_flag,
	output logic              critical_flag
);

	cfg_t cfg_q;
	logic wr_en;
	logic q_push, q_pop, q_full, q_empty;
	cmd_t push_data, pop_data;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.interval       <= INTERVAL_RST;
			cfg_q.settle         <= SETTLE_RST;
			cfg_q.low_level      <= LOW_RST;
			cfg_q.critical_level <= CRIT_RST;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_INTERVAL: cfg_q.interval       <= pwdata[ELAPSED_W-1:0];
				REG_SETTLE:   cfg_q.settle         <= pwdata[SETTLE_W-1:0];
				REG_LOW:      cfg_q.low_level      <= pwdata[PCT_W-1:0];
				REG_CRIT:     cfg_q.critical_level <= pwdata[PCT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_INTERVAL: prdata = DATA_W'(cfg_q.interval);
			REG_SETTLE:   prdata = DATA_W'(cfg_q.settle);
			REG_LOW:      prdata = DATA_W'(cfg_q.low_level);
			REG_CRIT:     prdata = DATA_W'(cfg_q.critical_level);
			default:      prdata = '0;
		endcase
	end

	bsfg_front #(
		.SAMPLES_PER_AVERAGE(SAMPLES_PER_AVERAGE)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.mode            (mode),
		.adc_mv          (adc_mv),
		.divider_request (divider_request),
		.cfg             (cfg_q),
		.q_full          (q_full),
		.q_push          (q_push),
		.q_data          (push_data)
	);

	bsfg_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (pop_data),
		.empty     (q_empty)
	);

	bsfg_back #(
		.SAMPLES_PER_AVERAGE(SAMPLES_PER_AVERAGE)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_empty       (q_empty),
		.q_pop         (q_pop),
		.q_data        (pop_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.divider_on    (divider_on),
		.sample_taken  (sample_taken),
		.updated       (updated),
		.battery_mv    (battery_mv),
		.percent       (percent),
		.low_flag      (low_flag),
		.critical_flag (critical_flag)
	);

endmodule

FILE: hdl/bsfg_checker.sv
// ----------------------------------------------------------------------------
// bsfg_checker
// Port-level checks on the fuel gauge result channel.
// ----------------------------------------------------------------------------
`include "battery_sampler_fuel_gauge_unit_macros.svh"

module bsfg_checker import bsfg_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_ready,
	input logic             divider_on,
	input logic             sample_taken,
	input logic             updated,
	input logic [MV_W-1:0]  battery_mv,
	input logic [PCT_W-1:0] percent
);

	`BSFG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(battery_mv) && $stable(percent), "result beat changed while stalled")
	`BSFG_ASSERT_NOW(a_upd_taken, out_valid && updated, sample_taken, "update without a latched reading")
	`BSFG_ASSERT_NOW(a_taken_div_off, out_valid && sample_taken, !divider_on, "divider still on after a reading")
	`BSFG_ASSERT_NOW(a_mv_even, out_valid && updated, !battery_mv[0], "battery voltage not doubled")
	`BSFG_ASSERT_NOW(a_pct_range, out_valid, percent <= 7'd100, "percent above 100")

endmodule

bind battery_sampler_fuel_gauge_unit bsfg_checker u_bsfg_checker (.*);
